@@ hw/rtl/crc8pf_pkg.sv @@
// ----------------------------------------------------------------------------
// crc8pf_pkg
// Types, constants and the CRC-8 byte update shared by the packet framer.
// ----------------------------------------------------------------------------
package crc8pf_pkg;

    localparam logic [7:0] CRC_POLY     = 8'h31;
    localparam logic [7:0] CRC_INIT     = 8'h00;
    localparam logic [7:0] HEADER_RESET = 8'h55;
    localparam logic [3:0] DEVICE_RESET = 4'h0;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID   = 1'b1;

    typedef enum logic [2:0] {
        K_HDR,
        K_CMD,
        K_LEN,
        K_DATA,
        K_CRC
    } t_kind;

    typedef struct packed {
        logic       first;
        logic [3:0] command;
        logic [7:0] payload_len;
        logic [7:0] data_byte;
        logic       has_data;
        logic       has_crc;
    } t_item;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/crc8pf_emit.sv @@
// ----------------------------------------------------------------------------
// crc8pf_emit
// Holds one framed item and sends its bytes one beat at a time, folding each
// byte but the trailing CRC byte into the running CRC as it leaves.
// ----------------------------------------------------------------------------
module crc8pf_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  crc8pf_pkg::t_item  i_item,
    output logic               o_take,
    input  logic [7:0]         i_header_byte,
    input  logic [3:0]         i_device_id,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);
    import crc8pf_pkg::*;

    logic       r_busy, n_busy;
    t_kind      r_kind, n_kind;
    t_item      r_item;
    logic [7:0] r_crc, n_crc;
    logic       w_end;
    logic       w_beat;
    logic [7:0] w_byte;

    assign w_end  = (r_kind == K_CRC) || ((r_kind == K_DATA) && !r_item.has_crc);
    assign w_beat = r_busy && i_out_ready;
    assign o_take = !r_busy || (i_out_ready && w_end);

    // next state
    always_comb begin
        n_busy = r_busy;
        n_kind = r_kind;
        if (w_beat && w_end) begin
            n_busy = 1'b0;
        end else if (w_beat) begin
            case (r_kind)
                K_HDR:   n_kind = K_CMD;
                K_CMD:   n_kind = K_LEN;
                K_LEN:   n_kind = r_item.has_data ? K_DATA : K_CRC;
                K_DATA:  n_kind = K_CRC;
                default: n_kind = r_kind;
            endcase
        end
        if (i_load) begin
            n_busy = 1'b1;
            n_kind = i_item.first ? K_HDR : K_DATA;
        end
    end

    // outputs
    always_comb begin
        case (r_kind)
            K_HDR:   w_byte = i_header_byte;
            K_CMD:   w_byte = {i_device_id, r_item.command};
            K_LEN:   w_byte = r_item.payload_len;
            K_DATA:  w_byte = r_item.data_byte;
            K_CRC:   w_byte = r_crc;
            default: w_byte = r_crc;
        endcase
    end

    always_comb begin
        n_crc = r_crc;
        if (w_beat) begin
            case (r_kind)
                K_HDR:   n_crc = crc8_update(CRC_INIT, w_byte);
                K_CRC:   n_crc = r_crc;
                default: n_crc = crc8_update(r_crc, w_byte);
            endcase
        end
    end

    assign o_out_valid = r_busy;
    assign o_out_byte  = w_byte;
    assign o_last      = (r_kind == K_CRC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= K_HDR;
            r_crc  <= CRC_INIT;
        end else begin
            r_busy <= n_busy;
            r_kind <= n_kind;
            r_crc  <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

endmodule

@@ hw/rtl/crc8_packet_framer.sv @@
// ----------------------------------------------------------------------------
// crc8_packet_framer
// Frames command packets with a CRC-8 (poly 0x31, init 0, MSB first).
// ----------------------------------------------------------------------------
// A start beat (first = 1) produces header, command, length, the first payload
// byte when the length is not zero, and the CRC when the payload ends there;
// each continuation beat produces its payload byte and, on the final one, the
// CRC. One byte leaves per output beat, and an item holds the block until its
// last byte is accepted: 1 or 2 bytes for a continuation, 4 or 5 for a
// start. The next item is taken in the same cycle as the previous item's final
// byte, so a stream of payload bytes runs at one per cycle while i_out_ready
// stays high. Continuation beats outside an open frame are taken and dropped.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module crc8_packet_framer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [crc8pf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [7:0]                          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_first,
    input  logic [3:0]                          i_command,
    input  logic [7:0]                          i_payload_len,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [7:0]                          o_out_byte,
    output logic                                o_last
);
    import crc8pf_pkg::*;

    logic [7:0] r_header_byte;
    logic [3:0] r_device_id;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic       w_take;
    logic       w_in_beat;
    logic       w_load;
    t_item      w_item;

    assign o_in_ready = w_take;
    assign w_in_beat  = i_in_valid && w_take;
    assign w_load     = w_in_beat && (i_first || (r_bytes_left != 8'd0));

    always_comb begin
        w_item.first       = i_first;
        w_item.command     = i_command;
        w_item.payload_len = i_payload_len;
        w_item.data_byte   = i_data_byte;
        if (i_first) begin
            w_item.has_data = (i_payload_len != 8'd0);
            w_item.has_crc  = (i_payload_len <= 8'd1);
            n_bytes_left    = (i_payload_len == 8'd0) ? 8'd0 : i_payload_len - 8'd1;
        end else begin
            w_item.has_data = 1'b1;
            w_item.has_crc  = (r_bytes_left == 8'd1);
            n_bytes_left    = (r_bytes_left == 8'd0) ? 8'd0 : r_bytes_left - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= HEADER_RESET;
            r_device_id   <= DEVICE_RESET;
            r_bytes_left  <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEADER_BYTE: r_header_byte <= i_cfg_data;
                    CFG_DEVICE_ID:   r_device_id   <= i_cfg_data[3:0];
                    default:         r_header_byte <= r_header_byte;
                endcase
            end
            if (w_in_beat) begin
                r_bytes_left <= n_bytes_left;
            end
        end
    end

    crc8pf_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_item        (w_item),
        .o_take        (w_take),
        .i_header_byte (r_header_byte),
        .i_device_id   (r_device_id),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

endmodule
